// ===== sv/nir_pkg.sv =====
// Shared types and constants for the NEC IR pulse-width decoder.
// No dependencies; used by nir_decode, nir_rsp_queue and the top level.
package nir_pkg;

   localparam int CFG_WIDTH   = 16;
   localparam int FRAME_BITS  = 32;
   localparam int BITS_CNT_W  = 6;
   localparam int HALF_WIDTH  = 16;
   localparam int CSR_IDX_W   = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEADER_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEADER_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_THRESH = 3'd4;

   // reset values
   localparam logic [CFG_WIDTH-1:0] LEADER_MIN_RST = 16'd8700;
   localparam logic [CFG_WIDTH-1:0] LEADER_MAX_RST = 16'd9300;
   localparam logic [CFG_WIDTH-1:0] REPEAT_MIN_RST = 16'd2000;
   localparam logic [CFG_WIDTH-1:0] REPEAT_MAX_RST = 16'd2400;
   localparam logic [CFG_WIDTH-1:0] ONE_THRESH_RST = 16'd1300;

   // frame status codes
   localparam logic [1:0] STATUS_FRAME  = 2'd0;
   localparam logic [1:0] STATUS_LEADER = 2'd1;
   localparam logic [1:0] STATUS_REPEAT = 2'd2;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] leader_min;
      logic [CFG_WIDTH-1:0] leader_max;
      logic [CFG_WIDTH-1:0] repeat_min;
      logic [CFG_WIDTH-1:0] repeat_max;
      logic [CFG_WIDTH-1:0] one_thresh;
   } cfg_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [HALF_WIDTH-1:0] address;
      logic [HALF_WIDTH-1:0] command;
   } result_type;

   typedef enum logic [6:0] {
      PH_IDLE         = 7'b0000001,
      PH_LEADER       = 7'b0000010,
      PH_SPACE        = 7'b0000100,
      PH_REPEAT_BURST = 7'b0001000,
      PH_BIT_BURST    = 7'b0010000,
      PH_BIT_SPACE    = 7'b0100000,
      PH_FINAL_BURST  = 7'b1000000
   } phase_type;

endpackage

// ===== sv/nec_ir_pulse_width_decoder_top.sv =====
// NEC infrared pulse-width decoder, one receiver sample per item.
// Each accepted item is one tick's sample of the active-low receiver line
// (0 = burst, 1 = space). The sample lands in an input register and is
// consumed by the decoder state machine when the queue has space; any
// result is pushed into a two-entry output queue. Sustained rate is one
// item per clock; the input stalls only while both queue entries hold
// results that rsp_ready has not taken. A result is pushed when the
// sample that ends the burst leaves the input register, and rsp_valid
// rises once the queue entry holding that result has been written.
// Results: status 0 with address (first 16 bits, MSB first) and command
// (last 16 bits) after the final burst; status 1 for a leader outside
// [leader_min, leader_max] at its rising edge; status 2 for a repeat code
// when the repeat burst ends. Durations saturate at 2^COUNT_WIDTH-1.
// Registers are written through csr_we/csr_index/csr_wdata; indexes above
// 4 are ignored. Write them only while the decoder is idle.
// Depends on nir_pkg, nir_decode and nir_rsp_queue.
module nec_ir_pulse_width_decoder_top #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // sample input
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_ir_level,
   // decoded results
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_frame_status,
   output logic [nir_pkg::HALF_WIDTH-1:0]  rsp_frame_address,
   output logic [nir_pkg::HALF_WIDTH-1:0]  rsp_frame_command,
   // register writes
   input  logic                            csr_we,
   input  logic [nir_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nir_pkg::CFG_WIDTH-1:0]   csr_wdata
);
   import nir_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        s0_valid_ff, s0_valid_in;
   logic        s0_level_ff;
   logic        q_space;
   logic        advance;
   logic        dec_valid;
   result_type  dec_res;
   result_type  q_data;

   // sample moves on when the queue can take a possible result
   assign advance   = s0_valid_ff && q_space;
   assign req_ready = !s0_valid_ff || advance;

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (req_valid && req_ready) begin
         s0_valid_in = 1'b1;
      end else if (advance) begin
         s0_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s0_level_ff <= req_ir_level;
      end
   end

   // config registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LEADER_MIN: cfg_in.leader_min = csr_wdata;
            CSR_LEADER_MAX: cfg_in.leader_max = csr_wdata;
            CSR_REPEAT_MIN: cfg_in.repeat_min = csr_wdata;
            CSR_REPEAT_MAX: cfg_in.repeat_max = csr_wdata;
            CSR_ONE_THRESH: cfg_in.one_thresh = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_min <= LEADER_MIN_RST;
         cfg_ff.leader_max <= LEADER_MAX_RST;
         cfg_ff.repeat_min <= REPEAT_MIN_RST;
         cfg_ff.repeat_max <= REPEAT_MAX_RST;
         cfg_ff.one_thresh <= ONE_THRESH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nir_decode #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step_level (s0_level_ff),
      .cfg        (cfg_ff),
      .res_valid  (dec_valid),
      .res        (dec_res)
   );

   nir_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (dec_valid),
      .push_data (dec_res),
      .has_space (q_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (q_data)
   );

   assign rsp_frame_status  = q_data.status;
   assign rsp_frame_address = q_data.address;
   assign rsp_frame_command = q_data.command;

endmodule

// ===== sv/nir_decode.sv =====
// Decoder state machine: times bursts and spaces, shifts in data bits.
// Depends on nir_pkg.
module nir_decode #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_valid,
   input  logic                step_level,
   input  nir_pkg::cfg_type    cfg,
   output logic                res_valid,
   output nir_pkg::result_type res
);
   import nir_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
   localparam logic [BITS_CNT_W-1:0]  LAST_BIT  = BITS_CNT_W'(FRAME_BITS - 1);

   phase_type               phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]  dur_ff, dur_in;
   logic [BITS_CNT_W-1:0]   bits_ff, bits_in;
   logic [FRAME_BITS-1:0]   shift_ff, shift_in;

   logic [COUNT_WIDTH-1:0]  dur_inc;
   logic [CMP_W-1:0]        dur_x;
   logic                    leader_bad;
   logic                    is_repeat;
   logic                    bit_one;

   assign dur_inc    = (dur_ff == COUNT_MAX) ? dur_ff : dur_ff + COUNT_ONE;
   assign dur_x      = CMP_W'(dur_ff);
   assign leader_bad = (dur_x < CMP_W'(cfg.leader_min)) || (dur_x > CMP_W'(cfg.leader_max));
   assign is_repeat  = (dur_x > CMP_W'(cfg.repeat_min)) && (dur_x < CMP_W'(cfg.repeat_max));
   assign bit_one    = dur_x > CMP_W'(cfg.one_thresh);

   always_comb begin
      phase_in    = phase_ff;
      dur_in      = dur_ff;
      bits_in     = bits_ff;
      shift_in    = shift_ff;
      res_valid   = 1'b0;
      res.status  = STATUS_FRAME;
      res.address = '0;
      res.command = '0;
      case (phase_ff)
         PH_LEADER: begin
            if (!step_level) begin
               dur_in = dur_inc;
            end else if (leader_bad) begin
               phase_in   = PH_IDLE;
               dur_in     = '0;
               res_valid  = 1'b1;
               res.status = STATUS_LEADER;
            end else begin
               phase_in = PH_SPACE;
               dur_in   = COUNT_ONE;
            end
         end
         PH_SPACE: begin
            if (step_level) begin
               dur_in = dur_inc;
            end else begin
               if (is_repeat) begin
                  phase_in = PH_REPEAT_BURST;
               end else begin
                  phase_in = PH_BIT_BURST;
                  bits_in  = '0;
                  shift_in = '0;
               end
               dur_in = '0;
            end
         end
         PH_REPEAT_BURST: begin
            if (step_level) begin
               phase_in   = PH_IDLE;
               res_valid  = 1'b1;
               res.status = STATUS_REPEAT;
            end
         end
         PH_BIT_BURST: begin
            if (step_level) begin
               phase_in = PH_BIT_SPACE;
               dur_in   = COUNT_ONE;
            end
         end
         PH_BIT_SPACE: begin
            if (step_level) begin
               dur_in = dur_inc;
            end else begin
               shift_in = {shift_ff[FRAME_BITS-2:0], bit_one};
               bits_in  = bits_ff + BITS_CNT_W'(1);
               dur_in   = '0;
               // count reaches the frame length on this bit
               phase_in = (bits_ff >= LAST_BIT) ? PH_FINAL_BURST : PH_BIT_BURST;
            end
         end
         PH_FINAL_BURST: begin
            if (step_level) begin
               phase_in    = PH_IDLE;
               res_valid   = 1'b1;
               res.status  = STATUS_FRAME;
               res.address = shift_ff[FRAME_BITS-1:HALF_WIDTH];
               res.command = shift_ff[HALF_WIDTH-1:0];
            end
         end
         default: begin
            // idle, and any stray code
            if (!step_level) begin
               phase_in = PH_LEADER;
               dur_in   = COUNT_ONE;
            end else begin
               phase_in = PH_IDLE;
            end
         end
      endcase
      if (!step_valid) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         dur_ff   <= '0;
         bits_ff  <= '0;
         shift_ff <= '0;
      end else if (step_valid) begin
         phase_ff <= phase_in;
         dur_ff   <= dur_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
      end
   end

endmodule

// ===== sv/nir_rsp_queue.sv =====
// Two-entry result queue decoupling the decoder from rsp_ready.
// Depends on nir_pkg.
module nir_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nir_pkg::result_type push_data,
   output logic                has_space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output nir_pkg::result_type rsp_data
);
   import nir_pkg::*;

   result_type  mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign has_space = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for nec_ir_pulse_width_decoder_top: drives receiver samples over
// valid/ready, predicts decoded frames, repeats and leader errors, and checks each one.
// Depends on nir_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb;
   import nir_pkg::*;

   localparam int          CYCLE_LIMIT = 2_000_000;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;   // saturation value at COUNT_WIDTH 16

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_ready;
   logic                  req_ir_level = 1'b1;
   logic                  rsp_valid;
   logic                  rsp_ready    = 1'b0;
   logic [1:0]            rsp_frame_status;
   logic [HALF_WIDTH-1:0] rsp_frame_address;
   logic [HALF_WIDTH-1:0] rsp_frame_command;
   logic                  csr_we       = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = CSR_LEADER_MIN;
   logic [CFG_WIDTH-1:0]  csr_wdata    = '0;

   // Decoder model state, mirrors the block's registers and state machine.
   cfg_type               dec_cfg;
   phase_type             dec_phase;
   logic [15:0]           dec_count;
   logic [5:0]            dec_nbits;
   logic [31:0]           dec_shift;
   result_type            expected_frames[$];

   // Bookkeeping
   bit                    steady = 1'b0;   // when set, neither side idles
   int                    cycle_count = 0;
   int                    n_samples = 0;
   int                    n_results = 0;
   int                    n_mismatch = 0;
   int                    n_settings = 0;
   int                    n_frames = 0;
   int                    n_repeats = 0;
   int                    n_leader_errs = 0;
   result_type            want_frame;

   nec_ir_pulse_width_decoder_top #(
      .COUNT_WIDTH (16)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_ir_level      (req_ir_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_frame_address (rsp_frame_address),
      .rsp_frame_command (rsp_frame_command),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs a handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side backpressure: stalls about 38% of cycles unless steady.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 38);
   end

   // ------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------
   function automatic void count_tick();
      if (dec_count != COUNT_MAX)
         dec_count = dec_count + 16'd1;
   endfunction

   function automatic void push_result(logic [1:0] status, logic [31:0] word);
      expected_frames.push_back('{status: status, address: word[31:16], command: word[15:0]});
   endfunction

   // Advance the model by one accepted sample; queue any result it causes.
   function automatic void decode_sample(logic level);
      case (dec_phase)
         PH_LEADER: begin
            if (!level) begin
               count_tick();
            end else if (dec_count < dec_cfg.leader_min || dec_count > dec_cfg.leader_max) begin
               dec_phase = PH_IDLE;
               dec_count = '0;
               push_result(STATUS_LEADER, '0);
            end else begin
               dec_phase = PH_SPACE;
               dec_count = 16'd1;
            end
         end
         PH_SPACE: begin
            if (level) begin
               count_tick();
            end else begin
               // a space strictly inside the window is a repeat code
               if (dec_count > dec_cfg.repeat_min && dec_count < dec_cfg.repeat_max) begin
                  dec_phase = PH_REPEAT_BURST;
               end else begin
                  dec_phase = PH_BIT_BURST;
                  dec_nbits = '0;
                  dec_shift = '0;
               end
               dec_count = '0;
            end
         end
         PH_REPEAT_BURST: begin
            if (level) begin
               dec_phase = PH_IDLE;
               push_result(STATUS_REPEAT, '0);
            end
         end
         PH_BIT_BURST: begin
            if (level) begin
               dec_phase = PH_BIT_SPACE;
               dec_count = 16'd1;
            end
         end
         PH_BIT_SPACE: begin
            if (level) begin
               count_tick();
            end else begin
               dec_shift = {dec_shift[30:0], dec_count > dec_cfg.one_thresh};
               dec_nbits = dec_nbits + 6'd1;
               dec_count = '0;
               dec_phase = (dec_nbits >= FRAME_BITS) ? PH_FINAL_BURST : PH_BIT_BURST;
            end
         end
         PH_FINAL_BURST: begin
            if (level) begin
               dec_phase = PH_IDLE;
               push_result(STATUS_FRAME, dec_shift);
            end
         end
         default: begin
            if (!level) begin
               dec_phase = PH_LEADER;
               dec_count = 16'd1;
            end else begin
               dec_phase = PH_IDLE;
            end
         end
      endcase
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_WIDTH-1:0] data);
      case (idx)
         CSR_LEADER_MIN: dec_cfg.leader_min = data;
         CSR_LEADER_MAX: dec_cfg.leader_max = data;
         CSR_REPEAT_MIN: dec_cfg.repeat_min = data;
         CSR_REPEAT_MAX: dec_cfg.repeat_max = data;
         CSR_ONE_THRESH: dec_cfg.one_thresh = data;
         default: ;   // unused indexes are dropped
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input result_type want);
      n_mismatch++;
      if (n_mismatch <= 10)
         $display("mismatch (%s) cycle %0d: expected status %0d addr %h cmd %h,",
                  what, cycle_count, want.status, want.address, want.command,
                  " got status %0d addr %h cmd %h",
                  rsp_frame_status, rsp_frame_address, rsp_frame_command);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         case (rsp_frame_status)
            STATUS_FRAME:  n_frames++;
            STATUS_REPEAT: n_repeats++;
            default:       n_leader_errs++;
         endcase
         if (expected_frames.size() == 0) begin
            report_mismatch("unexpected result", '0);
         end else begin
            want_frame = expected_frames.pop_front();
            if (rsp_frame_status !== want_frame.status ||
                rsp_frame_address !== want_frame.address ||
                rsp_frame_command !== want_frame.command)
               report_mismatch("field", want_frame);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // Send one sample item. Valid stays up between back-to-back items; random
   // idle cycles drop it first. The model advances at the accepting edge.
   task automatic send_sample(input logic level);
      while (!steady && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_ir_level <= level;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      n_samples++;
      decode_sample(level);
   endtask

   task automatic send_run(input logic level, input int count);
      for (int i = 0; i < count; i++)
         send_sample(level);
   endtask

   // Leader, space, then nbits data bits MSB first; a full frame also gets
   // its final burst and the rising edge that reports it.
   task automatic send_frame(input int leader_len, input int space_len,
                             input logic [31:0] word, input int nbits);
      int thr, lim, len;
      thr = dec_cfg.one_thresh;
      lim = (thr > 16) ? 16 : thr;
      send_run(1'b0, leader_len);
      send_run(1'b1, space_len);
      for (int i = 0; i < nbits; i++) begin
         send_run(1'b0, $urandom_range(1, 3));
         if (word[31-i])
            len = $urandom_range(1) ? thr + 1 : thr + 1 + $urandom_range(1, 3);
         else if (lim == 0)
            len = 1;
         else if ($urandom_range(1) && thr <= 16)
            len = thr;   // exactly on the threshold still decodes as zero
         else
            len = $urandom_range(1, lim);
         send_run(1'b1, len);
      end
      if (nbits == FRAME_BITS) begin
         send_run(1'b0, $urandom_range(1, 3));
         send_sample(1'b1);
      end
   endtask

   // Feed the level that moves the model forward until it is back in idle.
   task automatic settle_to_idle();
      while (dec_phase != PH_IDLE) begin
         case (dec_phase)
            PH_SPACE, PH_BIT_SPACE: send_sample(1'b0);
            default:                send_sample(1'b1);
         endcase
      end
   endtask

   // Sender holds off until every expected result is out, plus the
   // input-register and output-queue latency.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Reprogram all five thresholds with the decoder idle. A write to an
   // unused index goes first and must have no effect.
   task automatic program_thresholds(input int lmin, input int lmax, input int rmin,
                                     input int rmax, input int thr);
      logic [CSR_IDX_W-1:0] idx_list[6];
      logic [CFG_WIDTH-1:0] val_list[6];
      settle_to_idle();
      wait_for_results();
      idx_list = '{CSR_IDX_W'(CSR_ONE_THRESH + $urandom_range(1, 3)), CSR_LEADER_MIN,
                   CSR_LEADER_MAX, CSR_REPEAT_MIN, CSR_REPEAT_MAX, CSR_ONE_THRESH};
      val_list = '{CFG_WIDTH'($urandom_range(65535)), CFG_WIDTH'(lmin), CFG_WIDTH'(lmax),
                   CFG_WIDTH'(rmin), CFG_WIDTH'(rmax), CFG_WIDTH'(thr)};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx_list[i];
         csr_wdata <= val_list[i];
         apply_reg(idx_list[i], val_list[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      n_settings++;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Reset thresholds: leader and repeat window edges, threshold edge.
   task automatic test_reset_values();
      send_run(1'b0, 8699);   // one short of the leader minimum
      send_run(1'b1, 2);
      send_run(1'b0, 8700);   // shortest leader, space just above repeat minimum
      send_run(1'b1, 2001);
      send_run(1'b0, 3);
      send_run(1'b1, 2);
      send_run(1'b0, 9300);   // longest leader, space just below repeat maximum
      send_run(1'b1, 2399);
      send_run(1'b0, 3);
      send_run(1'b1, 2);
      send_run(1'b0, 9301);   // one past the leader maximum
      send_run(1'b1, 2);
      send_run(1'b0, 9000);   // space equal to repeat minimum starts data bits
      send_run(1'b1, 2000);
      settle_to_idle();
      send_run(1'b0, 9000);   // space equal to repeat maximum starts data bits
      send_run(1'b1, 2400);
      send_run(1'b0, 1);
      send_run(1'b1, 1301);   // one tick over the threshold: a one
      send_run(1'b0, 1);
      send_run(1'b1, 1300);   // exactly the threshold: a zero
      settle_to_idle();
   endtask

   // Compact thresholds so whole frames are cheap.
   task automatic test_directed_frames();
      program_thresholds(4, 6, 3, 6, 2);
      send_run(1'b0, 3);
      send_run(1'b1, 2);
      send_run(1'b0, 7);
      send_run(1'b1, 2);
      send_frame(4, 3, 32'hFFFF_0000, FRAME_BITS);
      send_run(1'b1, 3);
      send_frame(6, 6, 32'h0000_FFFF, FRAME_BITS);
      send_run(1'b1, 50);    // long idle high before the next leader
      send_frame(5, 1, 32'hA5A5_5A5A, FRAME_BITS);
      send_run(1'b0, 5);     // repeat, short burst
      send_run(1'b1, 4);
      send_run(1'b0, 1);
      send_run(1'b1, 1);
      send_run(1'b0, 5);     // repeat, long burst
      send_run(1'b1, 5);
      send_run(1'b0, 40);
      send_run(1'b1, 2);
      send_frame(4, 2, $urandom, 10);   // frame cut short, then flushed
      settle_to_idle();
      send_frame(5, 3, 32'h8000_0001, FRAME_BITS);
      send_run(1'b1, 1);
   endtask

   // Every register at 0 and at 65535, including inverted windows.
   task automatic test_extreme_limits();
      program_thresholds(0, 65535, 0, 65535, 0);
      send_run(1'b0, 1);     // one-tick leader accepted, one-tick space is a repeat
      send_run(1'b1, 1);
      send_run(1'b0, 1);
      send_run(1'b1, 2);
      program_thresholds(65535, 0, 65535, 0, 65535);
      send_run(1'b0, 5);     // inverted leader window rejects everything
      send_run(1'b1, 2);
      program_thresholds(0, 65535, 65535, 0, 65535);
      send_frame(2, 3, 32'h0000_0000, FRAME_BITS);
      send_run(1'b1, 2);
      program_thresholds(0, 65535, 5, 6, 0);   // empty repeat window, every bit a one
      send_frame(1, 6, 32'hFFFF_FFFF, FRAME_BITS);
      send_run(1'b1, 2);
   endtask

   // Leader longer than the counter range: the count must stick at its maximum.
   task automatic test_saturation();
      steady = 1'b1;
      program_thresholds(65535, 65535, 2, 5, 3);
      send_run(1'b0, 65600);
      send_run(1'b1, 3);
      send_run(1'b0, 2);
      send_run(1'b1, 2);
      wait_for_results();
      steady = 1'b0;
   endtask

   // Mostly well-formed frames, repeats and bad leaders with random content,
   // plus broken frames and noise; thresholds change every 500 samples.
   task automatic test_random_traffic();
      int items0, epoch, pick, lmin, lmax, rmin, rmax, space;
      items0 = n_samples;
      epoch  = -1;
      while ((n_samples - items0) < 2000) begin
         if ((n_samples - items0) / 500 != epoch) begin
            epoch  = (n_samples - items0) / 500;
            steady = (epoch == 2);
            lmin   = $urandom_range(2, 6);
            rmin   = $urandom_range(1, 4);
            program_thresholds(lmin, lmin + $urandom_range(0, 4), rmin,
                               rmin + $urandom_range(2, 5), $urandom_range(1, 4));
         end
         lmin  = dec_cfg.leader_min;
         lmax  = dec_cfg.leader_max;
         rmin  = dec_cfg.repeat_min;
         rmax  = dec_cfg.repeat_max;
         space = $urandom_range(1) ? $urandom_range(1, rmin) : $urandom_range(rmax, rmax + 3);
         pick  = $urandom_range(99);
         if (pick < 88)
            settle_to_idle();
         if (pick < 35) begin
            send_frame($urandom_range(lmin, lmax), space, $urandom, FRAME_BITS);
            send_run(1'b1, $urandom_range(1, 3));
         end else if (pick < 60) begin
            send_run(1'b0, $urandom_range(lmin, lmax));
            send_run(1'b1, $urandom_range(rmin + 1, rmax - 1));
            send_run(1'b0, $urandom_range(1, 4));
            send_run(1'b1, $urandom_range(1, 3));
         end else if (pick < 75) begin
            send_run(1'b0, $urandom_range(1) ? $urandom_range(1, lmin - 1)
                                             : $urandom_range(lmax + 1, lmax + 5));
            send_run(1'b1, $urandom_range(1, 3));
         end else if (pick < 88) begin
            send_frame($urandom_range(lmin, lmax), space, $urandom, $urandom_range(0, 31));
         end else begin
            repeat ($urandom_range(1, 20))
               send_sample($urandom_range(1));
         end
      end
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      dec_cfg   = '{leader_min: LEADER_MIN_RST, leader_max: LEADER_MAX_RST,
                    repeat_min: REPEAT_MIN_RST, repeat_max: REPEAT_MAX_RST,
                    one_thresh: ONE_THRESH_RST};
      dec_phase = PH_IDLE;
      dec_count = '0;
      dec_nbits = '0;
      dec_shift = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_directed_frames();
      test_extreme_limits();
      test_saturation();
      test_random_traffic();

      wait_for_results();
      repeat (8) @(posedge clock);
      if (expected_frames.size() != 0)
         report_mismatch("missing result", expected_frames[0]);

      $display("Sent %0d receiver samples under %0d threshold settings plus reset values.",
               n_samples, n_settings);
      $display("Checked %0d results: %0d frames, %0d repeat codes, %0d leader errors;",
               n_results, n_frames, n_repeats, n_leader_errs,
               " %0d mismatches.", n_mismatch);
      if (n_mismatch == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
